FILE: rtl/scalu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalu_pkg: shared types and constants
// Operation and error codes, widths and the per-stage beat record.
// ----------------------------------------------------------------------------
package scalu_pkg;

   localparam int WIDTH = 32;
   localparam int NCELLS = WIDTH;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_S_BELOW   = 3'd1,
      ERR_S_ABOVE   = 3'd2,
      ERR_S_DIVZERO = 3'd3,
      ERR_MIN_DIV_M1 = 3'd4,
      ERR_U_OVER    = 3'd5,
      ERR_U_UNDER   = 3'd6,
      ERR_U_DIVZERO = 3'd7
   } err_type;

   // Work carried along the cell chain. For divide, acc is the partial
   // remainder and quo the shifting dividend/quotient. For multiply, acc:quo
   // is the running product high:low.
   typedef struct packed {
      logic             valid;
      op_type           op;
      logic             sgn;
      logic             neg_res;
      logic             neg_rem;
      logic [WIDTH-1:0] acc;
      logic [WIDTH-1:0] quo;
      logic [WIDTH-1:0] mag_b;
      logic             done;
      logic [WIDTH-1:0] val;
      err_type          err;
   } beat_type;

endpackage

FILE: rtl/scalu_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalu_cell: one step of the multiply / divide chain
// Shift-add multiply step or restoring divide step, one bit per cell.
// ----------------------------------------------------------------------------
module scalu_cell
   import scalu_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  beat_type beat_i,
   output beat_type beat_o
);

   beat_type beat_ff, beat_in;
   logic [WIDTH:0] trial;
   logic [WIDTH:0] psum;

   always_comb begin
      beat_in = beat_i;
      trial = '0;
      psum = '0;
      if (!beat_i.done) begin
         if (beat_i.op == OP_DIV) begin
            trial = {beat_i.acc, beat_i.quo[WIDTH-1]} - {1'b0, beat_i.mag_b};
            if (!trial[WIDTH]) begin
               beat_in.acc = trial[WIDTH-1:0];
               beat_in.quo = {beat_i.quo[WIDTH-2:0], 1'b1};
            end else begin
               beat_in.acc = {beat_i.acc[WIDTH-2:0], beat_i.quo[WIDTH-1]};
               beat_in.quo = {beat_i.quo[WIDTH-2:0], 1'b0};
            end
         end else begin
            // quo holds the multiplier LSB first; acc the product high half
            psum = {1'b0, beat_i.acc} + (beat_i.quo[0] ? {1'b0, beat_i.val} : '0);
            beat_in.acc = psum[WIDTH:1];
            beat_in.quo = {psum[0], beat_i.quo[WIDTH-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else if (advance) begin
         beat_ff.valid <= beat_in.valid;
      end
      if (advance) begin
         beat_ff.op      <= beat_in.op;
         beat_ff.sgn     <= beat_in.sgn;
         beat_ff.neg_res <= beat_in.neg_res;
         beat_ff.neg_rem <= beat_in.neg_rem;
         beat_ff.acc     <= beat_in.acc;
         beat_ff.quo     <= beat_in.quo;
         beat_ff.mag_b   <= beat_in.mag_b;
         beat_ff.done    <= beat_in.done;
         beat_ff.val     <= beat_in.val;
         beat_ff.err     <= beat_in.err;
      end
   end

   assign beat_o = beat_ff;

endmodule

FILE: rtl/scalu_entry.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalu_entry: operand decode and add/subtract
// Takes magnitudes, resolves add, subtract and divide special cases.
// ----------------------------------------------------------------------------
module scalu_entry
   import scalu_pkg::*;
(
   input  logic             valid,
   input  logic [1:0]       action,
   input  logic             is_signed,
   input  logic [WIDTH-1:0] operand_a,
   input  logic [WIDTH-1:0] operand_b,
   output beat_type         beat_o
);

   localparam logic [WIDTH-1:0] MINV = {1'b1, {(WIDTH-1){1'b0}}};
   localparam logic [WIDTH-1:0] MAXV = {1'b0, {(WIDTH-1){1'b1}}};

   logic na, nb;
   logic [WIDTH-1:0] ma, mb;
   logic [WIDTH:0] usum, udif;

   always_comb begin
      na = is_signed & operand_a[WIDTH-1];
      nb = is_signed & operand_b[WIDTH-1];
      ma = na ? (~operand_a + 1'b1) : operand_a;
      mb = nb ? (~operand_b + 1'b1) : operand_b;
      usum = {1'b0, operand_a} + {1'b0, operand_b};
      udif = {1'b0, operand_a} - {1'b0, operand_b};
      beat_o = '0;
      beat_o.valid = valid;
      beat_o.op = op_type'(action);
      beat_o.sgn = is_signed;
      beat_o.neg_res = na ^ nb;
      beat_o.neg_rem = na;
      beat_o.mag_b = mb;
      beat_o.err = ERR_NONE;
      case (op_type'(action))
         OP_ADD: begin
            beat_o.done = 1'b1;
            beat_o.val = usum[WIDTH-1:0];
            if (is_signed) begin
               if (na == nb && usum[WIDTH-1] != na) begin
                  beat_o.err = na ? ERR_S_BELOW : ERR_S_ABOVE;
                  beat_o.val = na ? MINV : MAXV;
               end
            end else if (usum[WIDTH]) begin
               beat_o.err = ERR_U_OVER;
               beat_o.val = '1;
            end
         end
         OP_SUB: begin
            beat_o.done = 1'b1;
            beat_o.val = udif[WIDTH-1:0];
            if (is_signed) begin
               if (na != nb && udif[WIDTH-1] != na) begin
                  beat_o.err = na ? ERR_S_BELOW : ERR_S_ABOVE;
                  beat_o.val = na ? MINV : MAXV;
               end
            end else if (udif[WIDTH]) begin
               beat_o.err = ERR_U_UNDER;
               beat_o.val = '0;
            end
         end
         OP_MUL: begin
            beat_o.val = ma;   // multiplicand
            beat_o.quo = mb;   // multiplier
         end
         default: begin
            beat_o.quo = ma;
            if (operand_b == '0) begin
               beat_o.done = 1'b1;
               beat_o.err = is_signed ? ERR_S_DIVZERO : ERR_U_DIVZERO;
            end else if (is_signed && operand_b == '1 && operand_a == MINV) begin
               beat_o.done = 1'b1;
               beat_o.err = ERR_MIN_DIV_M1;
               beat_o.val = MAXV;
            end
         end
      endcase
   end

endmodule

FILE: rtl/saturating_checked_alu_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saturating_checked_alu_core: saturating checked integer ALU
// Channel  Dir  Beat fields, lowest bits first
// req      in   tuser = action[1:0], is_signed[2]
//               tdata = operand_a[31:0], operand_b[63:32]
// rsp      out  tdata = result_value[31:0], result_remainder[63:32]
//               tuser = status[2:0]
// One beat per cycle while the output is not stalled. WIDTH+1 register
// stages: one per cell of the bit-serial chain (one multiply or divide bit
// per cell) plus the output stage.
// The whole chain advances together; it holds when the output is stalled.
// Synchronous reset clears only valid flags.
// ----------------------------------------------------------------------------
module saturating_checked_alu_core
   import scalu_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [2*WIDTH-1:0]   req_tdata,   // operand_a, operand_b
   input  logic [2:0]           req_tuser,   // action, is_signed
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [2*WIDTH-1:0]   rsp_tdata,   // result_value, result_remainder
   output logic [2:0]           rsp_tuser    // status
);

   localparam logic [WIDTH-1:0] MINV = {1'b1, {(WIDTH-1){1'b0}}};
   localparam logic [WIDTH-1:0] MAXV = {1'b0, {(WIDTH-1){1'b1}}};

   beat_type chain [NCELLS+1];
   logic advance;
   logic [WIDTH-1:0] val_ff, val_in, rem_ff, rem_in;
   err_type err_ff, err_in;
   logic vld_ff;

   assign advance = !vld_ff || rsp_tready;
   assign req_tready = advance;

   scalu_entry u_entry (
      .valid     (req_tvalid),
      .action    (req_tuser[1:0]),
      .is_signed (req_tuser[2]),
      .operand_a (req_tdata[WIDTH-1:0]),
      .operand_b (req_tdata[2*WIDTH-1:WIDTH]),
      .beat_o    (chain[0])
   );

   for (genvar i = 0; i < NCELLS; i++) begin : g_cell
      scalu_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .advance(advance),
         .beat_i (chain[i]),
         .beat_o (chain[i+1])
      );
   end

   beat_type t;
   always_comb begin
      t = chain[NCELLS];
      val_in = t.val;
      rem_in = '0;
      err_in = t.err;
      if (!t.done) begin
         if (t.op == OP_DIV) begin
            val_in = t.neg_res ? (~t.quo + 1'b1) : t.quo;
            rem_in = t.neg_rem ? (~t.acc + 1'b1) : t.acc;
         end else if (t.sgn) begin
            if (t.neg_res) begin
               if (t.acc != '0 || t.quo > MINV) begin
                  err_in = ERR_S_BELOW;
                  val_in = MINV;
               end else begin
                  val_in = ~t.quo + 1'b1;
               end
            end else if (t.acc != '0 || t.quo > MAXV) begin
               err_in = ERR_S_ABOVE;
               val_in = MAXV;
            end else begin
               val_in = t.quo;
            end
         end else if (t.acc != '0) begin
            err_in = ERR_U_OVER;
            val_in = '1;
         end else begin
            val_in = t.quo;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (advance) begin
         vld_ff <= t.valid;
      end
      if (advance) begin
         val_ff <= val_in;
         rem_ff <= rem_in;
         err_ff <= err_in;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata = {rem_ff, val_ff};
   assign rsp_tuser = err_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser) && rsp_tvalid)
      else $error("output changed while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("not ready with empty output");
   a_divz: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (err_ff == ERR_S_DIVZERO || err_ff == ERR_U_DIVZERO)
      |-> val_ff == '0 && rem_ff == '0)
      else $error("divide by zero result not zero");

endmodule

FILE: verif/saturating_checked_alu_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saturating_checked_alu_core_test: self-checking bench for the checked ALU
// Directed table of boundary operands (saturation, divide by zero, min by
// minus one), then random add/sub/mul/div beats with bursty input, a stalling
// output and one long output hold-off. Results are checked in order, field by
// field, against table golden values or a local saturating arithmetic model.
// ----------------------------------------------------------------------------
module saturating_checked_alu_core_test;
   import scalu_pkg::*;

   localparam int N_RANDOM = 1600;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [31:0] MAXS = 32'h7fff_ffff;
   localparam logic [31:0] MINS = 32'h8000_0000;
   localparam logic [31:0] ONES = 32'hffff_ffff;

   typedef struct packed {
      op_type      op;
      logic        sgn;
      logic [31:0] a;
      logic [31:0] b;
   } alu_op_type;

   typedef struct packed {
      logic [31:0] val;
      logic [31:0] rem;
      err_type     err;
   } alu_res_type;

   typedef struct {
      alu_op_type  op;
      logic        has_golden;
      alu_res_type golden;
   } table_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [2:0]  rsp_tuser;

   alu_res_type pending_results[$];
   int       error_count = 0;
   int       results_seen = 0;
   int       idle_cycles = 0;
   int       err_hist[8];
   bit       long_hold = 1'b0;
   table_row_type table_rows[$];

   saturating_checked_alu_core DUT (.*);

   always #4 clock = ~clock;

   function automatic alu_res_type alu_compute(alu_op_type x);
      alu_res_type r;
      logic [32:0] s33;
      logic [63:0] prod;
      logic [31:0] ma;
      logic [31:0] mb;
      logic        na;
      logic        nb;
      r = '{val: '0, rem: '0, err: ERR_NONE};
      na = x.a[31];
      nb = x.b[31];
      ma = na ? -x.a : x.a;
      mb = nb ? -x.b : x.b;
      if (x.sgn) begin
         case (x.op)
            OP_ADD, OP_SUB: begin
               r.val = (x.op == OP_ADD) ? x.a + x.b : x.a - x.b;
               if (((x.op == OP_ADD) == (na == nb)) && (r.val[31] != na)) begin
                  r.err = na ? ERR_S_BELOW : ERR_S_ABOVE;
                  r.val = na ? MINS : MAXS;
               end
            end
            OP_MUL: begin
               prod = 64'(ma) * 64'(mb);
               if (na != nb) begin
                  if (prod > 64'(MINS)) begin
                     r.err = ERR_S_BELOW;
                     r.val = MINS;
                  end else r.val = -prod[31:0];
               end else if (prod > 64'(MAXS)) begin
                  r.err = ERR_S_ABOVE;
                  r.val = MAXS;
               end else r.val = prod[31:0];
            end
            default: begin
               if (x.b == 0) r.err = ERR_S_DIVZERO;
               else if (x.b == ONES && x.a == MINS) begin
                  r.err = ERR_MIN_DIV_M1;
                  r.val = MAXS;
               end else begin
                  r.val = (na != nb) ? -(ma / mb) : ma / mb;
                  r.rem = na ? -(ma % mb) : ma % mb;
               end
            end
         endcase
      end else begin
         case (x.op)
            OP_ADD: begin
               s33 = {1'b0, x.a} + {1'b0, x.b};
               if (s33[32]) begin
                  r.err = ERR_U_OVER;
                  r.val = ONES;
               end else r.val = s33[31:0];
            end
            OP_SUB: begin
               if (x.a < x.b) r.err = ERR_U_UNDER;
               else r.val = x.a - x.b;
            end
            OP_MUL: begin
               prod = 64'(x.a) * 64'(x.b);
               if (prod[63:32] != 0) begin
                  r.err = ERR_U_OVER;
                  r.val = ONES;
               end else r.val = prod[31:0];
            end
            default: begin
               if (x.b == 0) r.err = ERR_U_DIVZERO;
               else begin
                  r.val = x.a / x.b;
                  r.rem = x.a % x.b;
               end
            end
         endcase
      end
      return r;
   endfunction

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return MAXS;
         1: return MINS;
         2: return ONES;
         3: return 32'($urandom_range(0, 3));
         4: return -32'($urandom_range(1, 3));
         5: return 32'($urandom_range(0, 65535));
         6: return $urandom >> $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at result %0d: %s got %h expected %h", results_seen, what, got, want);
      error_count++;
   endtask

   task automatic add_row(op_type op, logic sgn, logic [31:0] a, logic [31:0] b,
                          logic has, logic [31:0] v = 0, logic [31:0] rm = 0,
                          err_type e = ERR_NONE);
      table_row_type t;
      t.op = '{op: op, sgn: sgn, a: a, b: b};
      t.has_golden = has;
      t.golden = '{val: v, rem: rm, err: e};
      table_rows.push_back(t);
   endtask

   task automatic send_beat(alu_op_type x, logic has, alu_res_type golden);
      alu_res_type r;
      r = has ? golden : alu_compute(x);
      req_tdata <= {x.b, x.a};
      req_tuser <= {x.sgn, x.op};
      req_tvalid <= 1'b1;
      pending_results.push_back(r);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic random_gap();
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // output side: stall pattern plus one long hold-off
   initial begin
      int k;
      k = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (150) @(posedge clock);
            long_hold = 1'b0;
         end
         k++;
         if (k % 400 < 120) rsp_tready <= 1'b1;
         else rsp_tready <= ($urandom_range(0, 3) != 0);
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      alu_res_type got;
      alu_res_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{val: rsp_tdata[31:0], rem: rsp_tdata[63:32], err: err_type'(rsp_tuser)};
         results_seen++;
         if (pending_results.size() == 0) begin
            $display("unexpected result beat %h %h", rsp_tuser, rsp_tdata);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            err_hist[got.err]++;
            if (got.val !== want.val) report_mismatch("value", got.val, want.val);
            if (got.rem !== want.rem) report_mismatch("remainder", got.rem, want.rem);
            if (got.err !== want.err) report_mismatch("error", 32'(got.err), 32'(want.err));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired, %0d results outstanding", pending_results.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      alu_op_type x;
      alu_res_type none;
      int burst;
      int guard;
      none = '{val: '0, rem: '0, err: ERR_NONE};
      add_row(OP_ADD, 1, MAXS, 1, 1, MAXS, 0, ERR_S_ABOVE);
      add_row(OP_ADD, 1, MINS, ONES, 1, MINS, 0, ERR_S_BELOW);
      add_row(OP_ADD, 1, MAXS, MINS, 1, ONES, 0, ERR_NONE);
      add_row(OP_SUB, 1, MINS, 1, 1, MINS, 0, ERR_S_BELOW);
      add_row(OP_SUB, 1, MAXS, ONES, 1, MAXS, 0, ERR_S_ABOVE);
      add_row(OP_SUB, 1, 0, MINS, 1, MAXS, 0, ERR_S_ABOVE);
      add_row(OP_MUL, 1, MINS, ONES, 1, MAXS, 0, ERR_S_ABOVE);
      add_row(OP_MUL, 1, MINS, 1, 1, MINS, 0, ERR_NONE);
      add_row(OP_MUL, 1, 32'h0001_0000, 32'hffff_0000, 1, MINS, 0, ERR_S_BELOW);
      add_row(OP_MUL, 1, MAXS, MAXS, 1, MAXS, 0, ERR_S_ABOVE);
      add_row(OP_DIV, 1, 5, 0, 1, 0, 0, ERR_S_DIVZERO);
      add_row(OP_DIV, 1, MINS, ONES, 1, MAXS, 0, ERR_MIN_DIV_M1);
      add_row(OP_DIV, 1, -32'd7, 2, 1, -32'd3, ONES, ERR_NONE);
      add_row(OP_DIV, 1, 7, -32'd2, 0);
      add_row(OP_DIV, 1, MINS, MAXS, 0);
      add_row(OP_ADD, 0, ONES, 1, 1, ONES, 0, ERR_U_OVER);
      add_row(OP_ADD, 0, ONES, 0, 1, ONES, 0, ERR_NONE);
      add_row(OP_SUB, 0, 0, 1, 1, 0, 0, ERR_U_UNDER);
      add_row(OP_SUB, 0, ONES, ONES, 1, 0, 0, ERR_NONE);
      add_row(OP_MUL, 0, ONES, ONES, 1, ONES, 0, ERR_U_OVER);
      add_row(OP_MUL, 0, 32'h0001_0000, 32'h0000_ffff, 0);
      add_row(OP_DIV, 0, ONES, 0, 1, 0, 0, ERR_U_DIVZERO);
      add_row(OP_DIV, 0, ONES, 1, 1, ONES, 0, ERR_NONE);
      add_row(OP_DIV, 0, 100, 7, 1, 14, 2, ERR_NONE);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (table_rows[i]) begin
         send_beat(table_rows[i].op, table_rows[i].has_golden, table_rows[i].golden);
         random_gap();
      end
      long_hold = 1'b1;
      for (int n = 0; n < N_RANDOM; ) begin
         burst = $urandom_range(1, 40);
         for (int j = 0; j < burst && n < N_RANDOM; j++, n++) begin
            x.op = op_type'($urandom_range(0, 3));
            x.sgn = $urandom_range(0, 1);
            x.a = pick_operand();
            x.b = pick_operand();
            send_beat(x, 1'b0, none);
         end
         random_gap();
      end
      req_tvalid <= 1'b0;
      guard = 0;
      while (pending_results.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (60) @(posedge clock);
      $display("%0d beats checked over all ops and signedness; error code counts:",
               results_seen);
      $display("  %0d %0d %0d %0d %0d %0d %0d %0d", err_hist[0], err_hist[1], err_hist[2],
               err_hist[3], err_hist[4], err_hist[5], err_hist[6], err_hist[7]);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
